### hdl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  // Product-term width: 2*(a*b + c*d) of Q1.15 values, plus the 1.0 offset
  localparam int unsigned TermW = 34;
  // CORDIC vector width: term width plus gain and pre-rotation growth
  localparam int unsigned VecW = 36;
  // Angle width at scale 2^24
  localparam int unsigned AngW = 28;
  // Radicand and square-root working width
  localparam int unsigned RadW = 62;
  // Square-root result digits
  localparam int unsigned SqrtSteps = 31;

  localparam logic signed [AngW-1:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [17:0] OutPi = 18'sd25736;
  localparam logic signed [17:0] OutHalfPi = 18'sd12868;

  // Side data that travels beside the square-root cells
  typedef struct packed {
    logic signed [TermW-1:0] sr;
    logic signed [TermW-1:0] cr;
    logic signed [TermW-1:0] sy;
    logic signed [TermW-1:0] cy;
    logic signed [TermW-1:0] sp;
    logic                    clamp;
  } side_t;

  // One CORDIC lane
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } lane_t;

  // atan(2^-i) at scale 2^24
  function automatic logic signed [AngW-1:0] atan_of(input int unsigned i);
    logic signed [AngW-1:0] a;
    case (i)
      0:  a = 28'sd13176795;
      1:  a = 28'sd7778716;
      2:  a = 28'sd4110060;
      3:  a = 28'sd2086331;
      4:  a = 28'sd1047214;
      5:  a = 28'sd524117;
      6:  a = 28'sd262123;
      7:  a = 28'sd131069;
      8:  a = 28'sd65536;
      9:  a = 28'sd32768;
      10: a = 28'sd16384;
      11: a = 28'sd8192;
      12: a = 28'sd4096;
      13: a = 28'sd2048;
      14: a = 28'sd1024;
      15: a = 28'sd512;
      16: a = 28'sd256;
      17: a = 28'sd128;
      18: a = 28'sd64;
      19: a = 28'sd32;
      20: a = 28'sd16;
      21: a = 28'sd8;
      22: a = 28'sd4;
      23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hdl/qte_sqrt_cell.sv
`timescale 1ns / 1ps
module qte_sqrt_cell
  import qte_pkg::*;
#(
  parameter int unsigned K = 30
) (
  input  logic            clk_i,
  input  logic [RadW-1:0] v_i,
  input  logic [RadW-1:0] r_i,
  output logic [RadW-1:0] v_o,
  output logic [RadW-1:0] r_o
);

  localparam logic [RadW-1:0] BitVal = RadW'(1) << (2 * K);

  logic [RadW-1:0] trial;
  logic [RadW-1:0] v_d, r_d, v_q, r_q;

  // Try one result digit: subtract when the remainder allows it
  always_comb begin
    trial = r_i + BitVal;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + BitVal;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  // Hand the partial root to the next cell
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

### hdl/qte_cordic_cell.sv
`timescale 1ns / 1ps
module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic  clk_i,
  input  lane_t lane_i,
  output lane_t lane_o
);

  localparam logic signed [AngW-1:0] Atan = atan_of(STAGE);

  logic signed [VecW-1:0] xs, ys;
  lane_t lane_d, lane_q;

  // Rotate toward the x axis by atan(2^-STAGE)
  always_comb begin
    xs = lane_i.x >>> STAGE;
    ys = lane_i.y >>> STAGE;
    lane_d = lane_i;
    if (!lane_i.y[VecW-1]) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + Atan;
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - Atan;
    end
  end

  // Pass the vector on to the next cell
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

### hdl/quaternion_to_euler_angles_core.sv
// Pipeline from the accepting edge to the done_o cycle: 4 product/radicand stages,
// 31 square-root cells, pre-rotation, CORDIC cells, output.
// Throughput: one quaternion per cycle; busy_o stays low, every cell advances each cycle.
// The receiver cannot stall: each result shows for exactly one cycle with done_o.
// Reset clears only the valid pipeline; data registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_core
  import qte_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               done_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);

  localparam int unsigned Lat = CORDIC_STAGES + 37;
  localparam int unsigned SideN = SqrtSteps + 2;

  logic accept;
  logic [Lat-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Advance the valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  // Capture the input transfer
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= quat_x_i;
      qy_q <= quat_y_i;
      qz_q <= quat_z_i;
      qw_q <= quat_w_i;
    end
  end

  // Form the product terms
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  side_t side_b_d, side_b_q;
  always_comb begin
    p_wx = qw_q * qx_q;
    p_yz = qy_q * qz_q;
    p_xx = qx_q * qx_q;
    p_yy = qy_q * qy_q;
    p_wz = qw_q * qz_q;
    p_xy = qx_q * qy_q;
    p_zz = qz_q * qz_q;
    p_wy = qw_q * qy_q;
    p_zx = qz_q * qx_q;
    side_b_d.sr = (TermW'(p_wx) + TermW'(p_yz)) <<< 1;
    side_b_d.cr = (TermW'(1) <<< 30) - ((TermW'(p_xx) + TermW'(p_yy)) <<< 1);
    side_b_d.sy = (TermW'(p_wz) + TermW'(p_xy)) <<< 1;
    side_b_d.cy = (TermW'(1) <<< 30) - ((TermW'(p_yy) + TermW'(p_zz)) <<< 1);
    side_b_d.sp = (TermW'(p_wy) - TermW'(p_zx)) <<< 1;
    side_b_d.clamp = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    side_b_q <= side_b_d;
  end

  // Square the pitch term and detect saturation
  logic signed [TermW-1:0] sp_abs;
  logic [30:0] sp_mag;
  logic [RadW-1:0] sq_d, sq_q, rad_q;
  side_t side_c_d;
  side_t side_q [0:SideN-1];

  always_comb begin
    side_c_d = side_b_q;
    side_c_d.clamp = (side_b_q.sp >= (TermW'(1) <<< 30)) ||
                     (side_b_q.sp <= -(TermW'(1) <<< 30));
    sp_abs = side_b_q.sp[TermW-1] ? -side_b_q.sp : side_b_q.sp;
    sp_mag = side_c_d.clamp ? '0 : sp_abs[30:0];
    sq_d = RadW'(sp_mag) * RadW'(sp_mag);
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    rad_q <= (RadW'(1) << 60) - sq_q;
    side_q[0] <= side_c_d;
    for (int unsigned j = 1; j < SideN; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // Square-root cell chain, one digit per cell
  logic [RadW-1:0] sv [0:SqrtSteps];
  logic [RadW-1:0] sr [0:SqrtSteps];
  assign sv[0] = rad_q;
  assign sr[0] = '0;

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    qte_sqrt_cell #(
      .K(SqrtSteps - 1 - j)
    ) u_cell (
      .clk_i(clk_i),
      .v_i  (sv[j]),
      .r_i  (sr[j]),
      .v_o  (sv[j+1]),
      .r_o  (sr[j+1])
    );
  end

  // Pre-rotate each atan2 vector into the right half plane
  function automatic lane_t pre_rot(input logic signed [VecW-1:0] y,
                                    input logic signed [VecW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x[VecW-1]) begin
      if (!y[VecW-1]) begin
        l.x = y;
        l.y = -x;
        l.z = AngHalfPi;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -AngHalfPi;
      end
    end
    return l;
  endfunction

  side_t side_p;
  logic [30:0] root;
  lane_t lane [0:2][0:CORDIC_STAGES];
  logic [1:0] cl_q [0:CORDIC_STAGES];

  assign side_p = side_q[SideN-1];
  assign root = sr[SqrtSteps][30:0];

  always_ff @(posedge clk_i) begin
    lane[0][0] <= pre_rot(VecW'(side_p.sr), VecW'(side_p.cr));
    lane[1][0] <= pre_rot(VecW'(side_p.sp), VecW'(root));
    lane[2][0] <= pre_rot(VecW'(side_p.sy), VecW'(side_p.cy));
    cl_q[0] <= {side_p.clamp, ~side_p.sp[TermW-1]};
    for (int unsigned i = 1; i <= CORDIC_STAGES; i++) begin
      cl_q[i] <= cl_q[i-1];
    end
  end

  // CORDIC cell rows: roll, pitch, yaw
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      qte_cordic_cell #(
        .STAGE(i)
      ) u_cell (
        .clk_i (clk_i),
        .lane_i(lane[l][i]),
        .lane_o(lane[l][i+1])
      );
    end
  end

  // Round to scale 2^13 and saturate
  function automatic logic signed [17:0] to_out(input lane_t l,
                                                input logic signed [17:0] lim);
    logic signed [AngW:0] zr;
    logic signed [17:0] r;
    zr = (AngW+1)'(l.z) + (AngW+1)'(1024);
    r = 18'(zr >>> 11);
    if (l.zero) r = '0;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [17:0] roll_w, pitch_w, yaw_w;
  logic [1:0] cl_last;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic clamp_q;

  always_comb begin
    cl_last = cl_q[CORDIC_STAGES];
    roll_w = to_out(lane[0][CORDIC_STAGES], OutPi);
    yaw_w = to_out(lane[2][CORDIC_STAGES], OutPi);
    if (cl_last[1]) begin
      pitch_w = cl_last[0] ? OutHalfPi : -OutHalfPi;
    end else begin
      pitch_w = to_out(lane[1][CORDIC_STAGES], OutHalfPi);
    end
  end

  // Hold the result for its one-cycle transfer
  always_ff @(posedge clk_i) begin
    roll_q <= roll_w[15:0];
    pitch_q <= pitch_w[14:0];
    yaw_q <= yaw_w[15:0];
    clamp_q <= cl_last[1];
  end

  assign done_o = vld_q[Lat-1];
  assign roll_angle_o = roll_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o = yaw_q;
  assign pitch_clamped_o = clamp_q;

  // Every accepted transfer yields exactly one result after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Lat done_o)
    else $error("result missing after fixed latency");

  a_clamp_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pitch_clamped_o) |->
      (pitch_angle_o == 15'sd12868 || pitch_angle_o == -15'sd12868))
    else $error("clamped pitch not at +-pi/2");

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= 16'sd25736 && roll_angle_o >= -16'sd25736 &&
                yaw_angle_o <= 16'sd25736 && yaw_angle_o >= -16'sd25736))
    else $error("roll or yaw out of range");

endmodule
